// File: src/dhs_pkg.sv
// ----------------------------------------------------------------------------
// dhs_pkg
// Shared constants, control word and status types for the disk harmonic
// series evaluator, plus the microcode table of its sequencer.
// ----------------------------------------------------------------------------
package dhs_pkg;

    // table depth and derived widths
    localparam int MAX_TERMS = 32;
    localparam int AW        = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CW        = $clog2(MAX_TERMS + 1);

    // field widths
    localparam int COEF_W     = 32;
    localparam int XY_W       = 18;
    localparam int SUM_W      = 48;
    localparam int TC_W       = 6;
    localparam int IDX_W      = 5;
    localparam int FRAC       = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // op codes of an input item
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CONSTANT_TERM = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_COUNT    = 1'd1;

    // microcode steps
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_WAIT   = 3'd0;
    localparam step_t STEP_SQUARE = 3'd1;
    localparam step_t STEP_RADIUS = 3'd2;
    localparam step_t STEP_MUL    = 3'd3;
    localparam step_t STEP_ACC    = 3'd4;
    localparam step_t STEP_EMIT   = 3'd5;

    // jump conditions
    typedef enum logic [2:0] {
        JC_NEXT,    // fall through to the next step
        JC_ALWAYS,  // unconditional jump
        JC_WAIT,    // jump unless an evaluate item arrives
        JC_SKIP,    // jump when outside the disk or no terms
        JC_LOOP     // jump while terms remain
    } jump_cond_t;

    // one control word
    typedef struct packed {
        logic       sq_en;
        logic       rad_en;
        logic       mul_en;
        logic       acc_en;
        logic       emit;
        jump_cond_t cond;
        step_t      target;
    } ctrl_word_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic skip;
        logic more;
    } dp_status_t;

    // microcode program
    function automatic ctrl_word_t ucode_rom(input step_t step);
        ctrl_word_t w;
        w = '{sq_en: 1'b0, rad_en: 1'b0, mul_en: 1'b0, acc_en: 1'b0, emit: 1'b0,
              cond: JC_ALWAYS, target: STEP_WAIT};
        case (step)
            STEP_WAIT:
            begin
                w.cond   = JC_WAIT;
                w.target = STEP_WAIT;
            end
            STEP_SQUARE:
            begin
                w.sq_en = 1'b1;
                w.cond  = JC_NEXT;
            end
            STEP_RADIUS:
            begin
                w.rad_en = 1'b1;
                w.cond   = JC_SKIP;
                w.target = STEP_EMIT;
            end
            STEP_MUL:
            begin
                w.mul_en = 1'b1;
                w.cond   = JC_NEXT;
            end
            STEP_ACC:
            begin
                w.acc_en = 1'b1;
                w.cond   = JC_LOOP;
                w.target = STEP_MUL;
            end
            STEP_EMIT:
            begin
                w.emit   = 1'b1;
                w.cond   = JC_ALWAYS;
                w.target = STEP_WAIT;
            end
            default:
            begin
                w.cond   = JC_ALWAYS;
                w.target = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

// File: src/dhs_seq.sv
// ----------------------------------------------------------------------------
// dhs_seq
// Step counter and microcode lookup; picks the next step from the jump
// condition of the current control word.
// ----------------------------------------------------------------------------
module dhs_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                eval_start,
    input  dhs_pkg::dp_status_t status,
    output dhs_pkg::ctrl_word_t ctrl,
    output logic                busy
);
    import dhs_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  taken;

    // control word of the current step
    assign ctrl = ucode_rom(step_reg);
    assign busy = (step_reg != STEP_WAIT);

    // jump decision
    always_comb
    begin
        case (ctrl.cond)
            JC_NEXT:   taken = 1'b0;
            JC_ALWAYS: taken = 1'b1;
            JC_WAIT:   taken = !eval_start;
            JC_SKIP:   taken = status.skip;
            JC_LOOP:   taken = status.more;
            default:   taken = 1'b1;
        endcase
        step_next = taken ? ctrl.target : step_reg + step_t'(1);
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// File: src/dhs_coef_tab.sv
// ----------------------------------------------------------------------------
// dhs_coef_tab
// Cosine and sine coefficient tables, one write port and one read port,
// cleared to zero at reset.
// ----------------------------------------------------------------------------
module dhs_coef_tab (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [dhs_pkg::AW-1:0]            wr_index,
    input  logic signed [dhs_pkg::COEF_W-1:0] wr_cos,
    input  logic signed [dhs_pkg::COEF_W-1:0] wr_sin,
    input  logic [dhs_pkg::AW-1:0]            rd_index,
    output logic signed [dhs_pkg::COEF_W-1:0] rd_cos,
    output logic signed [dhs_pkg::COEF_W-1:0] rd_sin
);
    import dhs_pkg::*;

    logic signed [COEF_W-1:0] cos_reg [MAX_TERMS];
    logic signed [COEF_W-1:0] sin_reg [MAX_TERMS];

    // coefficient storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TERMS; i++)
            begin
                cos_reg[i] <= '0;
                sin_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            cos_reg[wr_index] <= wr_cos;
            sin_reg[wr_index] <= wr_sin;
        end
    end

    // read of the current term
    assign rd_cos = cos_reg[rd_index];
    assign rd_sin = sin_reg[rd_index];

endmodule

// File: src/dhs_datapath.sv
// ----------------------------------------------------------------------------
// dhs_datapath
// Radius check, power of z by complex multiplication, coefficient products
// and the running sum, each stage enabled by the control word.
// ----------------------------------------------------------------------------
module dhs_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dhs_pkg::ctrl_word_t               ctrl,
    input  logic                              load,
    input  logic signed [dhs_pkg::XY_W-1:0]   x_coord,
    input  logic signed [dhs_pkg::XY_W-1:0]   y_coord,
    input  logic signed [dhs_pkg::COEF_W-1:0] constant_term,
    input  logic [dhs_pkg::TC_W-1:0]          term_count,
    input  logic signed [dhs_pkg::COEF_W-1:0] rd_cos,
    input  logic signed [dhs_pkg::COEF_W-1:0] rd_sin,
    output logic [dhs_pkg::AW-1:0]            rd_index,
    output dhs_pkg::dp_status_t               status,
    output logic signed [dhs_pkg::SUM_W-1:0]  field_value,
    output logic                              outside_disk,
    output logic                              done
);
    import dhs_pkg::*;

    localparam int SQ_W = 2 * XY_W;
    localparam int PC_W = COEF_W + XY_W;
    localparam int TC_S = PC_W - FRAC;
    localparam int PW_S = SQ_W - FRAC;
    localparam logic [SQ_W-1:0] R2_ONE = SQ_W'(64'h1_0000_0000);

    // point, power and sum
    logic signed [XY_W-1:0]  x_reg, y_reg, re_reg, im_reg;
    logic signed [XY_W-1:0]  re_next, im_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CW-1:0]           k_reg, n_reg, n_eff, k_inc;
    logic                    outside_reg;

    // squares for the radius check
    logic signed [SQ_W-1:0]  sq_x, sq_y;
    logic [SQ_W-2:0]         xx_reg, yy_reg;
    logic [SQ_W-1:0]         r2;
    logic                    r2_over;

    // products of one term
    logic signed [PC_W-1:0]  pc_reg, ps_reg;
    logic signed [SQ_W-1:0]  prx_reg, piy_reg, pry_reg, pix_reg;
    logic signed [TC_S-1:0]  tc, ts;
    logic signed [PW_S-1:0]  rx, iy, ry, ix;
    logic signed [PW_S:0]    re_sum, im_sum;

    // result registers
    logic signed [SUM_W-1:0] field_value_reg;
    logic                    outside_disk_reg;
    logic                    done_reg;

    // clamp degree to the table depth
    always_comb
    begin
        if (int'(term_count) > MAX_TERMS)
        begin
            n_eff = CW'(MAX_TERMS);
        end
        else
        begin
            n_eff = CW'(term_count);
        end
    end

    // radius and loop status
    assign sq_x    = x_reg * x_reg;
    assign sq_y    = y_reg * y_reg;
    assign r2      = {1'b0, xx_reg} + {1'b0, yy_reg};
    assign r2_over = (r2 > R2_ONE);
    assign k_inc   = k_reg + CW'(1);

    assign status.skip = r2_over || (k_reg >= n_reg);
    assign status.more = (k_inc < n_reg);
    assign rd_index    = k_reg[AW-1:0];

    // truncated products and next values
    always_comb
    begin
        tc       = pc_reg[PC_W-1:FRAC];
        ts       = ps_reg[PC_W-1:FRAC];
        rx       = prx_reg[SQ_W-1:FRAC];
        iy       = piy_reg[SQ_W-1:FRAC];
        ry       = pry_reg[SQ_W-1:FRAC];
        ix       = pix_reg[SQ_W-1:FRAC];
        re_sum   = rx - iy;
        im_sum   = ry + ix;
        re_next  = re_sum[XY_W-1:0];
        im_next  = im_sum[XY_W-1:0];
        sum_next = sum_reg + SUM_W'(tc) + SUM_W'(ts);
    end

    // payload datapath
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg   <= x_coord;
            y_reg   <= y_coord;
            re_reg  <= x_coord;
            im_reg  <= y_coord;
            sum_reg <= SUM_W'(constant_term);
            k_reg   <= CW'(1);
            n_reg   <= n_eff;
        end
        if (ctrl.sq_en)
        begin
            xx_reg <= sq_x[SQ_W-2:0];
            yy_reg <= sq_y[SQ_W-2:0];
        end
        if (ctrl.mul_en)
        begin
            pc_reg  <= rd_cos * re_reg;
            ps_reg  <= rd_sin * im_reg;
            prx_reg <= re_reg * x_reg;
            piy_reg <= im_reg * y_reg;
            pry_reg <= re_reg * y_reg;
            pix_reg <= im_reg * x_reg;
        end
        if (ctrl.acc_en)
        begin
            sum_reg <= sum_next;
            re_reg  <= re_next;
            im_reg  <= im_next;
            k_reg   <= k_inc;
        end
        if (ctrl.rad_en)
        begin
            outside_reg <= r2_over;
        end
        if (ctrl.emit)
        begin
            field_value_reg  <= outside_reg ? '0 : sum_reg;
            outside_disk_reg <= outside_reg;
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.emit;
        end
    end

    assign field_value  = field_value_reg;
    assign outside_disk = outside_disk_reg;
    assign done         = done_reg;

endmodule

// File: src/disk_harmonic_series_eval_unit.sv
// ----------------------------------------------------------------------------
// disk_harmonic_series_eval_unit
// Evaluates a0 + sum of an[i]*Re(z^i) + bn[i]*Im(z^i) at a point in the unit
// disk, with coefficient tables loaded by write items.
// ----------------------------------------------------------------------------
// Write items give no result and do not make the block busy.
// Evaluate: square and radius steps, then multiply and accumulate steps of
// the shared datapath per term; an outside point or no terms skips to emit.
// No item is taken while busy; the next item is taken in the cycle done is
// high. Reset clears the tables, constant term, done and the step counter and
// sets the term count to 1, not the datapath registers; no stall.
// ----------------------------------------------------------------------------
module disk_harmonic_series_eval_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 op,
    input  logic [dhs_pkg::IDX_W-1:0]            term_index,
    input  logic signed [dhs_pkg::COEF_W-1:0]    cos_weight,
    input  logic signed [dhs_pkg::COEF_W-1:0]    sin_weight,
    input  logic signed [dhs_pkg::XY_W-1:0]      x_coord,
    input  logic signed [dhs_pkg::XY_W-1:0]      y_coord,
    input  logic                                 cfg_we,
    input  logic [dhs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dhs_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                 done,
    output logic signed [dhs_pkg::SUM_W-1:0]     field_value,
    output logic                                 outside_disk
);
    import dhs_pkg::*;

    logic signed [COEF_W-1:0] constant_term_reg;
    logic [TC_W-1:0]          term_count_reg;

    logic                     accept;
    logic                     eval_start;
    logic                     wr_en;
    ctrl_word_t               ctrl;
    dp_status_t               status;
    logic [AW-1:0]            rd_index;
    logic signed [COEF_W-1:0] rd_cos, rd_sin;

    // item acceptance
    assign accept     = start && !busy;
    assign eval_start = accept && (op == OP_EVAL);
    assign wr_en      = accept && (op == OP_WRITE) && (int'(term_index) < MAX_TERMS);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            constant_term_reg <= '0;
            term_count_reg    <= TC_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CONSTANT_TERM: constant_term_reg <= cfg_data;
                CFG_TERM_COUNT:    term_count_reg    <= cfg_data[TC_W-1:0];
                default:           ;
            endcase
        end
    end

    // sequencer
    dhs_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .eval_start (eval_start),
        .status     (status),
        .ctrl       (ctrl),
        .busy       (busy)
    );

    // coefficient tables
    dhs_coef_tab u_tab (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (AW'(term_index)),
        .wr_cos   (cos_weight),
        .wr_sin   (sin_weight),
        .rd_index (rd_index),
        .rd_cos   (rd_cos),
        .rd_sin   (rd_sin)
    );

    // arithmetic
    dhs_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .load          (eval_start),
        .x_coord       (x_coord),
        .y_coord       (y_coord),
        .constant_term (constant_term_reg),
        .term_count    (term_count_reg),
        .rd_cos        (rd_cos),
        .rd_sin        (rd_sin),
        .rd_index      (rd_index),
        .status        (status),
        .field_value   (field_value),
        .outside_disk  (outside_disk),
        .done          (done)
    );

    // a result only follows a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a preceding evaluation");

    // an accepted evaluate item makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_EVAL)) |=> busy)
        else $error("evaluate item did not start the sequence");

    // a write item never starts the sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_WRITE)) |=> !busy)
        else $error("write item started the sequence");

    // a point outside the disk gives zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && outside_disk) |-> (field_value == '0))
        else $error("outside point gave a nonzero value");

endmodule
